FILE: src/pbat_pkg.sv
// Shared types, constants and helpers for the pending build aging table.
`default_nettype none

package pbat_pkg;

  // Table geometry
  localparam int TABLE_DEPTH = 16;
  localparam int MAX_RESULTS = 16;
  localparam int SLOT_W      = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int KCNT_W      = $clog2(MAX_RESULTS + 1);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Result status codes
  localparam logic [1:0] STATUS_OK       = 2'd0;
  localparam logic [1:0] STATUS_NOTFOUND = 2'd1;
  localparam logic [1:0] STATUS_FULL     = 2'd2;

  typedef enum logic [1:0] {
    OP_OPEN   = 2'd0,
    OP_CLOSE  = 2'd1,
    OP_COVERS = 2'd2,
    OP_EXPIRE = 2'd3
  } op_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_CALC,
    ST_DECIDE,
    ST_FINISH
  } state_t;

  // Input word
  typedef struct packed {
    logic [1:0]  command;
    logic [31:0] table_id;
    logic [63:0] index_id;
    logic [63:0] now_time;
  } in_t;

  // Result word
  typedef struct packed {
    logic [1:0]  status;
    logic        entry_valid;
    logic [31:0] expired_table_id;
    logic [63:0] expired_index_id;
    logic [63:0] expired_open_time;
    logic        last;
  } out_t;

  // Decoded command as held in the queue
  typedef struct packed {
    op_t         op;
    logic [31:0] table_id;
    logic [63:0] index_id;
    logic [63:0] now_time;
  } cmd_t;

  // Queue head as seen by the back end
  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } qhead_t;

  // One table entry
  typedef struct packed {
    logic [31:0] table_id;
    logic [63:0] index_id;
    logic [63:0] opened;
  } entry_t;

  function automatic out_t make_result(logic [1:0] status, logic has_entry,
                                       entry_t ent, logic last);
    out_t r;
    r.status            = status;
    r.entry_valid       = has_entry;
    r.expired_table_id  = has_entry ? ent.table_id : 32'd0;
    r.expired_index_id  = has_entry ? ent.index_id : 64'd0;
    r.expired_open_time = has_entry ? ent.opened   : 64'd0;
    r.last              = last;
    return r;
  endfunction

endpackage

`default_nettype wire

FILE: src/pbat_front.sv
// Front end: accepts input words, decodes the command and queues it.
`default_nettype none

module pbat_front
  import pbat_pkg::*;
(
  input  wire logic   clk,
  input  wire logic   rst,
  input  wire logic   in_valid,
  output logic        in_ready,
  input  wire in_t    in_word,
  output qhead_t      head,
  input  wire logic   pop
);

  cmd_t               q_mem [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr;
  logic [QPTR_W-1:0]  rd_ptr;
  logic [QCNT_W-1:0]  q_count;
  logic               push;
  logic               do_pop;
  cmd_t               decoded;

  // Decode the incoming word
  always_comb begin
    decoded.op       = op_t'(in_word.command);
    decoded.table_id = in_word.table_id;
    decoded.index_id = in_word.index_id;
    decoded.now_time = in_word.now_time;
  end

  assign in_ready   = (q_count != QCNT_W'(QUEUE_DEPTH));
  assign push       = in_valid && in_ready;
  assign do_pop     = pop && (q_count != '0);
  assign head.valid = (q_count != '0);
  assign head.cmd   = q_mem[rd_ptr];

  // Queue storage
  always_ff @(posedge clk) begin
    if (push) begin
      q_mem[wr_ptr] <= decoded;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr  <= '0;
      rd_ptr  <= '0;
      q_count <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      case ({push, do_pop})
        2'b10:   q_count <= q_count + 1'b1;
        2'b01:   q_count <= q_count - 1'b1;
        default: q_count <= q_count;
      endcase
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    q_count <= QCNT_W'(QUEUE_DEPTH))
    else $error("queue count beyond depth");

endmodule

`default_nettype wire

FILE: src/pbat_back.sv
// Back end: table storage, the slot walker that runs each command, and the result register.
`default_nettype none

module pbat_back
  import pbat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire qhead_t      head,
  output logic             pop,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_word
);

  entry_t             mem [TABLE_DEPTH];
  state_t             state;
  state_t             state_next;
  cmd_t               cmd;
  logic [CNT_W-1:0]   count;
  logic [CNT_W-1:0]   walk_idx;
  logic [CNT_W-1:0]   keep;
  logic [KCNT_W-1:0]  k_cnt;
  logic               found;
  logic               open_full;
  logic               held_valid;
  entry_t             held;
  entry_t             rd;
  logic [64:0]        diff;
  logic               match_idx;
  logic               match_tab;
  logic [63:0]        ceiling;

  logic               load_ok;
  logic               remove;
  logic               step_ok;
  logic               last_slot;
  logic               mem_we;
  logic [SLOT_W-1:0]  mem_waddr;
  entry_t             mem_wdata;
  logic               out_load;
  out_t               out_next;

  assign load_ok   = !out_valid || out_ready;
  assign last_slot = ((walk_idx + CNT_W'(1)) == count);

  // Removal decision for the slot under evaluation
  always_comb begin
    case (cmd.op)
      OP_CLOSE:  remove = !found && match_idx;
      OP_EXPIRE: remove = !diff[64] && (diff[63:0] >= ceiling) &&
                          (k_cnt < KCNT_W'(MAX_RESULTS));
      default:   remove = 1'b0;
    endcase
  end

  // An expiry with an entry already held must hand that one to the output first
  assign step_ok = !(remove && (cmd.op == OP_EXPIRE) && held_valid) || load_ok;

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (head.valid) begin
          if (head.cmd.op == OP_OPEN || count == '0) begin
            state_next = ST_FINISH;
          end else begin
            state_next = ST_READ;
          end
        end
      end
      ST_READ:   state_next = ST_CALC;
      ST_CALC:   state_next = ST_DECIDE;
      ST_DECIDE: begin
        if (step_ok) begin
          state_next = last_slot ? ST_FINISH : ST_READ;
        end
      end
      ST_FINISH: begin
        if (load_ok) begin
          state_next = ST_IDLE;
        end
      end
      default:   state_next = ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    pop       = 1'b0;
    mem_we    = 1'b0;
    mem_waddr = keep[SLOT_W-1:0];
    mem_wdata = rd;
    out_load  = 1'b0;
    out_next  = make_result(STATUS_OK, 1'b0, held, 1'b1);
    case (state)
      ST_IDLE: begin
        pop = head.valid;
        if (head.valid && head.cmd.op == OP_OPEN && count != CNT_W'(TABLE_DEPTH)) begin
          mem_we             = 1'b1;
          mem_waddr          = count[SLOT_W-1:0];
          mem_wdata.table_id = head.cmd.table_id;
          mem_wdata.index_id = head.cmd.index_id;
          mem_wdata.opened   = head.cmd.now_time;
        end
      end
      ST_DECIDE: begin
        if (remove) begin
          if (cmd.op == OP_EXPIRE && held_valid) begin
            out_load = load_ok;
            out_next = make_result(STATUS_OK, 1'b1, held, 1'b0);
          end
        end else begin
          // survivor moves down to the compacted position
          mem_we = 1'b1;
        end
      end
      ST_FINISH: begin
        out_load = load_ok;
        case (cmd.op)
          OP_OPEN:
            out_next = make_result(open_full ? STATUS_FULL : STATUS_OK, 1'b0, held, 1'b1);
          OP_EXPIRE:
            out_next = make_result(STATUS_OK, held_valid, held, 1'b1);
          default:
            out_next = make_result(found ? STATUS_OK : STATUS_NOTFOUND, 1'b0, held, 1'b1);
        endcase
      end
      default: ;
    endcase
  end

  // Table storage, registered read
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    if (state == ST_READ) begin
      rd <= mem[walk_idx[SLOT_W-1:0]];
    end
  end

  // Walker datapath
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && head.valid) begin
      cmd <= head.cmd;
    end
    if (state == ST_CALC) begin
      diff      <= {1'b0, cmd.now_time} - {1'b0, rd.opened};
      match_idx <= (rd.index_id == cmd.index_id);
      match_tab <= (rd.table_id == cmd.table_id);
    end
    if (state == ST_DECIDE && step_ok && remove && cmd.op == OP_EXPIRE) begin
      held <= rd;
    end
    if (out_load) begin
      out_word <= out_next;
    end
  end

  // Control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      count      <= '0;
      walk_idx   <= '0;
      keep       <= '0;
      k_cnt      <= '0;
      found      <= 1'b0;
      open_full  <= 1'b0;
      held_valid <= 1'b0;
      ceiling    <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_wr_en) begin
        ceiling <= cfg_wr_data;
      end
      case (state)
        ST_IDLE: begin
          if (head.valid) begin
            walk_idx   <= '0;
            keep       <= '0;
            k_cnt      <= '0;
            found      <= 1'b0;
            held_valid <= 1'b0;
            open_full  <= (count == CNT_W'(TABLE_DEPTH));
            if (head.cmd.op == OP_OPEN && count != CNT_W'(TABLE_DEPTH)) begin
              count <= count + 1'b1;
            end
          end
        end
        ST_DECIDE: begin
          if (step_ok) begin
            walk_idx <= walk_idx + 1'b1;
            if (remove) begin
              found <= 1'b1;
              if (cmd.op == OP_EXPIRE) begin
                held_valid <= 1'b1;
                k_cnt      <= k_cnt + 1'b1;
              end
            end else begin
              keep <= keep + 1'b1;
            end
            if (cmd.op == OP_COVERS && match_tab) begin
              found <= 1'b1;
            end
          end
        end
        ST_FINISH: begin
          if (load_ok && cmd.op != OP_OPEN) begin
            count <= keep;
          end
        end
        default: ;
      endcase
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= CNT_W'(TABLE_DEPTH))
    else $error("entry count beyond table depth");

  a_keep_behind: assert property (@(posedge clk) disable iff (rst)
    (state == ST_READ || state == ST_CALC || state == ST_DECIDE) |->
      (keep <= walk_idx && walk_idx < count))
    else $error("compaction pointer ahead of walker");

  a_emit_bound: assert property (@(posedge clk) disable iff (rst)
    k_cnt <= KCNT_W'(MAX_RESULTS))
    else $error("too many expired entries in one sweep");

  a_pop_idle: assert property (@(posedge clk) disable iff (rst)
    pop |-> (state == ST_IDLE && state_next != ST_IDLE))
    else $error("queue popped outside idle");

endmodule

`default_nettype wire

FILE: src/pending_build_aging_table.sv
// Top level of the pending build aging table: front queue plus table engine.
//
// Usage:
//   in_valid/in_ready carry one command word (open, close, covers, expire).
//   out_valid/out_ready carry result words; every command gives one or more,
//   and the final one for a command has last set. An expire sweep gives one
//   word per expired entry (up to 16), or one empty word if none expired.
//   cfg_wr_en/cfg_wr_data write the expiry ceiling; write only while idle.
// Command flow:
//   A two-entry command queue takes words while the engine is busy.
//   Open goes from the queue head through the finish state into the result
//   register. Close, covers and expire walk the used slots through one
//   table read port, each slot passing through the read, calc and decide
//   states: the registered read, the 64-bit age subtraction and the ceiling
//   compare, each in its own state.
// Reset: rst (synchronous) empties the table and the queue and clears the
//   ceiling to zero; entry contents are not cleared.
// Back-pressure: when out_ready is low the engine holds its place and the
//   queue keeps taking words until it is full, then in_ready drops.
`default_nettype none

module pending_build_aging_table
  import pbat_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire in_t         in_word,
  output logic             out_valid,
  input  wire logic        out_ready,
  output out_t             out_word,
  input  wire logic        cfg_wr_en,
  input  wire logic [63:0] cfg_wr_data
);

  qhead_t head;
  logic   pop;

  pbat_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_word  (in_word),
    .head     (head),
    .pop      (pop)
  );

  pbat_back u_back (
    .clk         (clk),
    .rst         (rst),
    .head        (head),
    .pop         (pop),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word)
  );

endmodule

`default_nettype wire

FILE: tb/sv/pbat_checker.sv
`timescale 1ns / 1ps
// Result checker for the pending build aging table: table predictor and word compare.
module pbat_checker
  import pbat_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  in_t         in_word,
  input  logic        out_valid,
  input  logic        out_ready,
  input  out_t        out_word,
  input  logic        cfg_wr_en,
  input  logic [63:0] cfg_wr_data,
  output int          fail_count,
  output int          results_due
);

  // Predicted table contents, oldest entry at slot 0
  entry_t      slots [TABLE_DEPTH];
  int unsigned fill;
  logic [63:0] ceiling;
  out_t        pending_results[$];

  // Result word without an entry, closing its command
  function automatic out_t status_word(logic [1:0] st);
    out_t r;
    r        = '0;
    r.status = st;
    r.last   = 1'b1;
    return r;
  endfunction

  // Report one differing field
  function automatic bit field_differs(string name, logic [63:0] want, logic [63:0] got);
    if (got === want) return 1'b0;
    $display("%0t: %s expected %h actual %h", $time, name, want, got);
    return 1'b1;
  endfunction

  // Append one predicted word at the tail
  task automatic queue_result(input out_t r);
    pending_results.insert(pending_results.size(), r);
  endtask

  // Apply one command to the predicted table and queue the words it yields
  task automatic apply_table_op(input in_t w);
    out_t        r;
    out_t        held;
    bit          have_held;
    bit          found;
    int unsigned hit;
    int unsigned keep;
    int          taken;
    case (w.command)
      OP_OPEN: begin
        if (fill >= TABLE_DEPTH) begin
          queue_result(status_word(STATUS_FULL));
        end else begin
          slots[fill] = '{table_id: w.table_id, index_id: w.index_id, opened: w.now_time};
          fill++;
          queue_result(status_word(STATUS_OK));
        end
      end
      OP_CLOSE: begin
        found = 1'b0;
        hit   = 0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (!found && slots[i].index_id == w.index_id) begin
            found = 1'b1;
            hit   = i;
          end
        end
        if (found) begin
          // shift the younger entries down over the closed one
          for (int unsigned j = hit; j + 1 < fill; j++) slots[j] = slots[j + 1];
          fill--;
          queue_result(status_word(STATUS_OK));
        end else begin
          queue_result(status_word(STATUS_NOTFOUND));
        end
      end
      OP_COVERS: begin
        found = 1'b0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (slots[i].table_id == w.table_id) found = 1'b1;
        end
        queue_result(status_word(found ? STATUS_OK : STATUS_NOTFOUND));
      end
      default: begin
        // sweep: emit aged entries in order, compact survivors in place
        taken     = 0;
        keep      = 0;
        have_held = 1'b0;
        held      = '0;
        for (int unsigned i = 0; i < fill; i++) begin
          if (w.now_time >= slots[i].opened && w.now_time - slots[i].opened >= ceiling &&
              taken < MAX_RESULTS) begin
            if (have_held) queue_result(held);
            r                   = '0;
            r.status            = STATUS_OK;
            r.entry_valid       = 1'b1;
            r.expired_table_id  = slots[i].table_id;
            r.expired_index_id  = slots[i].index_id;
            r.expired_open_time = slots[i].opened;
            held      = r;
            have_held = 1'b1;
            taken++;
          end else begin
            slots[keep] = slots[i];
            keep++;
          end
        end
        fill = keep;
        if (have_held) begin
          held.last = 1'b1;
          queue_result(held);
        end else begin
          queue_result(status_word(STATUS_OK));
        end
      end
    endcase
  endtask

  // Watch both channels and the register port at each edge
  always @(posedge clk) begin
    out_t want;
    bit   bad;
    if (rst) begin
      fill    = 0;
      ceiling = '0;
      pending_results.delete();
      fail_count = 0;
    end else begin
      if (out_valid === 1'b1 && out_ready) begin
        if (pending_results.size() == 0) begin
          $display("%0t: result word expected none actual %h", $time, out_word);
          fail_count++;
        end else begin
          want = pending_results.pop_front();
          bad  = field_differs("status", 64'(want.status), 64'(out_word.status))
               | field_differs("entry_valid", 64'(want.entry_valid),
                               64'(out_word.entry_valid))
               | field_differs("expired_table_id", 64'(want.expired_table_id),
                               64'(out_word.expired_table_id))
               | field_differs("expired_index_id", want.expired_index_id,
                               out_word.expired_index_id)
               | field_differs("expired_open_time", want.expired_open_time,
                               out_word.expired_open_time)
               | field_differs("last", 64'(want.last), 64'(out_word.last));
          if (bad) fail_count++;
        end
      end
      if (cfg_wr_en) ceiling = cfg_wr_data;
      if (in_valid && in_ready) apply_table_op(in_word);
    end
    results_due = pending_results.size();
  end

endmodule

FILE: tb/sv/tb.sv
`timescale 1ns / 1ps
// Testbench top for the pending build aging table: stimulus, flow control and verdict.
module tb;
  import pbat_pkg::*;

  logic        clk         = 1'b0;
  logic        rst         = 1'b1;
  logic        in_valid    = 1'b0;
  in_t         in_word     = '0;
  logic        out_ready   = 1'b0;
  logic        cfg_wr_en   = 1'b0;
  logic [63:0] cfg_wr_data = '0;
  logic        in_ready;
  logic        out_valid;
  out_t        out_word;
  int          fail_count;
  int          results_due;

  bit          gaps_on   = 1'b1;
  bit          stalls_on = 1'b1;
  int unsigned ready_hold = 0;
  logic [63:0] clock_ns;
  logic [63:0] index_pool [8];
  logic [31:0] table_pool [6];

  always #10 clk = ~clk;

  pending_build_aging_table uut (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  pbat_checker chk (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (in_valid),
    .in_ready    (in_ready),
    .in_word     (in_word),
    .out_valid   (out_valid),
    .out_ready   (out_ready),
    .out_word    (out_word),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .fail_count  (fail_count),
    .results_due (results_due)
  );

  // Idle length: mostly short, now and then long
  function automatic int gap_len();
    if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
    return $urandom_range(0, 2);
  endfunction

  function automatic in_t mk_word(op_t op, logic [31:0] tid, logic [63:0] iid,
                                  logic [63:0] now_ns);
    in_t w;
    w.command  = op;
    w.table_id = tid;
    w.index_id = iid;
    w.now_time = now_ns;
    return w;
  endfunction

  // Result side: random stalls while enabled
  always @(posedge clk) begin
    if (ready_hold != 0) begin
      ready_hold <= ready_hold - 1;
    end else if (stalls_on && $urandom_range(0, 2) == 0) begin
      out_ready  <= 1'b0;
      ready_hold <= gap_len();
    end else begin
      out_ready  <= 1'b1;
      ready_hold <= $urandom_range(0, 5);
    end
  end

  // Offer one command word and hold it until taken
  task automatic send_word(input in_t w);
    int gap;
    bit taken;
    gap = gaps_on ? gap_len() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    taken = 1'b0;
    while (!taken) begin
      @(negedge clk);
      taken = (in_ready === 1'b1);
      @(posedge clk);
    end
  endtask

  // Wait until every predicted word has come back
  task automatic drain();
    in_valid <= 1'b0;
    do @(negedge clk); while (results_due != 0);
    @(posedge clk);
  endtask

  task automatic write_ceiling(input logic [63:0] v);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= v;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  // Random command with ids drawn mostly from small pools so closes and covers hit
  task automatic random_word(output in_t w);
    int pick;
    int tsel;
    pick = $urandom_range(0, 99);
    if (pick < 40)      w.command = OP_OPEN;
    else if (pick < 60) w.command = OP_CLOSE;
    else if (pick < 75) w.command = OP_COVERS;
    else                w.command = OP_EXPIRE;
    w.table_id = ($urandom_range(0, 4) == 0) ? $urandom : table_pool[$urandom_range(0, 5)];
    w.index_id = ($urandom_range(0, 4) == 0) ? {$urandom, $urandom}
                                             : index_pool[$urandom_range(0, 7)];
    clock_ns = clock_ns + $urandom_range(0, 400);
    tsel = $urandom_range(0, 9);
    if (tsel == 0)
      w.now_time = {$urandom, $urandom};
    else if (tsel == 1)
      w.now_time = clock_ns - $urandom_range(0, 2000);
    else if (w.command == OP_OPEN)
      w.now_time = clock_ns + $urandom_range(0, 300);   // sometimes opened in the future
    else
      w.now_time = clock_ns;
  endtask

  initial begin
    in_t         w;
    logic [63:0] ceilings [6];

    index_pool[0] = '0;
    index_pool[1] = '1;
    for (int i = 2; i < 8; i++) index_pool[i] = {$urandom, $urandom};
    table_pool[0] = '0;
    table_pool[1] = '1;
    for (int i = 2; i < 6; i++) table_pool[i] = $urandom;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty table, fill to full, duplicates, both sweep extremes
    write_ceiling('1);
    send_word(mk_word(OP_COVERS, 32'd3, '0, '0));
    send_word(mk_word(OP_CLOSE, '0, 64'd9, '0));
    send_word(mk_word(OP_EXPIRE, '0, '0, '1));
    send_word(mk_word(OP_OPEN, '0, '0, '0));
    send_word(mk_word(OP_OPEN, '1, '1, '1));
    send_word(mk_word(OP_OPEN, 32'd7, 64'd5, 64'd50));
    send_word(mk_word(OP_OPEN, 32'd7, 64'd5, 64'd50));
    for (int i = 4; i < TABLE_DEPTH; i++)
      send_word(mk_word(OP_OPEN, $urandom, {$urandom, $urandom}, 64'(i * 20)));
    send_word(mk_word(OP_OPEN, 32'd1, 64'd1, 64'd1));          // table full, dropped
    send_word(mk_word(OP_COVERS, '1, '0, '0));
    send_word(mk_word(OP_CLOSE, '0, 64'd5, '0));               // oldest duplicate goes
    send_word(mk_word(OP_CLOSE, '0, 64'h1234_5678_9abc_def0, '0));
    send_word(mk_word(OP_EXPIRE, '0, '0, '1));                 // full-range age only
    write_ceiling('0);
    send_word(mk_word(OP_EXPIRE, '0, '0, 64'd100));            // later opens not yet due

    // Random phases, each under its own ceiling
    ceilings[0] = 64'd0;
    ceilings[1] = 64'd1;
    ceilings[2] = 64'd500;
    ceilings[3] = 64'd3000;
    ceilings[4] = {$urandom, $urandom};
    ceilings[5] = '1;
    clock_ns = 64'd1000;
    for (int p = 0; p < 6; p++) begin
      write_ceiling(ceilings[p]);
      gaps_on   = (p != 2) && ($urandom_range(0, 3) != 0);
      stalls_on <= (p != 2) && ($urandom_range(0, 3) != 0);
      for (int n = 0; n < 18; n++) begin
        random_word(w);
        send_word(w);
      end
    end

    drain();
    repeat (60) @(posedge clk);
    @(negedge clk);
    if (fail_count == 0 && results_due == 0)
      $display("TB_OK");
    else
      $display("TB_ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #10_000_000;
    $display("TB_ERROR");
    $finish;
  end

endmodule

FILE: pending_build_aging_table.f
src/pbat_pkg.sv
src/pbat_front.sv
src/pbat_back.sv
src/pending_build_aging_table.sv
tb/sv/pbat_checker.sv
tb/sv/tb.sv
